/* src/bilateral_depth_filter_assert.svh */
// Assertion macros used by the bilateral depth filter top level.
`ifndef BILATERAL_DEPTH_FILTER_ASSERT_SVH
`define BILATERAL_DEPTH_FILTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BDF_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bilateral depth filter assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BDF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bilateral depth filter assertion failed");

`endif

/* src/bdf_pkg.sv */
// Package with types, constants and table functions of the bilateral depth filter.
package bdf_pkg;

    localparam int MAX_WIDTH_DEF       = 256;
    localparam int MAX_HEIGHT_DEF      = 256;
    localparam int MAX_RADIUS_DEF      = 7;
    localparam int DEPTH_BITS_DEF      = 24;
    localparam int EXP_TABLE_DEPTH_DEF = 256;

    localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_FILTER_RADIUS = 3'd2;
    localparam logic [2:0] REG_SPATIAL_SCALE = 3'd3;
    localparam logic [2:0] REG_RANGE_SCALE   = 3'd4;

    localparam logic KIND_STORE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  pixel_x;
        logic [7:0]  pixel_y;
        logic [23:0] depth_in;
    } in_item_t;

    typedef struct packed {
        logic [23:0] smoothed_depth;
        logic        bad_coordinate;
    } out_item_t;

    // Ratio exp(-x) in Q0.32 from a truncated Taylor series, x given in Q.32.
    function automatic logic [63:0] exp_ratio(logic [63:0] x);
        logic [63:0] sum;
        logic [63:0] term;
        sum  = 64'd1 << 32;
        term = 64'd1 << 32;
        for (int k = 1; k <= 12; k++) begin
            term = ((term * x) >> 32) / 64'(k);
            if ((k % 2) == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        return sum;
    endfunction

    // Weight table entry idx in Q1.16, built by repeated rounded products in Q2.30.
    function automatic logic [16:0] exp_entry(logic [63:0] r, int idx);
        logic [63:0] t;
        t = 64'd1 << 30;
        for (int i = 1; i <= idx; i++) begin
            t = (t * r + (64'd1 << 31)) >> 32;
        end
        return 17'((t + (64'd1 << 13)) >> 14);
    endfunction

endpackage

/* src/bdf_divider.sv */
// Restoring divider that produces one quotient bit per cycle.
module bdf_divider #(
    parameter int NW = 50,
    parameter int EW = 25,
    parameter int QW = 24
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] numer,
    input  logic [EW-1:0] denom,
    output logic          done,
    output logic [QW-1:0] quotient
);

    localparam int RMW = (NW > EW + QW) ? NW : EW + QW;
    localparam int CTW = (QW > 1) ? $clog2(QW) : 1;

    logic [RMW-1:0] rem_reg;
    logic [RMW-1:0] dsh_reg;
    logic [QW-1:0]  q_reg;
    logic [CTW-1:0] cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic           fits;

    assign fits     = rem_reg >= dsh_reg;
    assign done     = done_reg;
    assign quotient = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CTW'(QW - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // The quotient is known to fit in QW bits, so the divisor starts at its top weight.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= RMW'(numer);
            dsh_reg <= RMW'(denom) << (QW - 1);
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
                rem_reg <= rem_reg - dsh_reg;
            dsh_reg <= dsh_reg >> 1;
            q_reg   <= {q_reg[QW-2:0], fits};
        end
    end

endmodule

/* src/bilateral_depth_filter.sv */
// Top level of the bilateral depth filter: frame memory, window walk and weight pipeline.
//
//  channel  dir  handshake              word
//  in       in   in_valid / in_ready    bdf_pkg::in_item_t (store or query)
//  out      out  out_valid / out_ready  bdf_pkg::out_item_t
//  cfg      in   cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// A store or an off-frame item goes from idle straight to finish; a query first reads its
// centre and finishes at once if that is empty. Any other query walks its window with one
// frame memory read per cycle, lets the 6-stage weight pipeline drain, then waits for the
// divider, which yields one bit a cycle. in_ready is high only while no item is in work;
// one finished word may wait in the output register, and the next one holds the block until
// out_ready takes it. Reset is asynchronous, active low, and does not clear the frame memory.
`include "bilateral_depth_filter_assert.svh"

module bilateral_depth_filter #(
    parameter int MAX_WIDTH       = bdf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT      = bdf_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_RADIUS      = bdf_pkg::MAX_RADIUS_DEF,
    parameter int DEPTH_BITS      = bdf_pkg::DEPTH_BITS_DEF,
    parameter int EXP_TABLE_DEPTH = bdf_pkg::EXP_TABLE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bdf_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output bdf_pkg::out_item_t result_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int DB   = DEPTH_BITS;
    localparam int AW   = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int RW   = $clog2(MAX_RADIUS + 1);
    localparam int DXW  = RW + 1;
    localparam int CW   = (DXW > 8) ? DXW + 2 : 10;
    localparam int DSW  = $clog2(2 * MAX_RADIUS * MAX_RADIUS + 1);
    localparam int TIW  = $clog2(EXP_TABLE_DEPTH);
    localparam int CNTW = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
    localparam int SWW  = 17 + CNTW;
    localparam int SDW  = DB + 17 + CNTW;
    localparam int SPW  = DSW + 16;
    localparam int RGW  = 52;
    localparam int AAW  = ((SPW + 24 > RGW) ? SPW + 24 : RGW) + 1;
    localparam int IXW  = AAW + TIW + 1;
    localparam logic [63:0] EXP_STEP  = 64'((64'd16 << 32) / EXP_TABLE_DEPTH);
    localparam logic [63:0] EXP_RATIO = bdf_pkg::exp_ratio(EXP_STEP);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_CENTRE    = 3'd1;
    localparam logic [2:0] ST_WALK      = 3'd2;
    localparam logic [2:0] ST_DRAIN     = 3'd3;
    localparam logic [2:0] ST_DIV_START = 3'd4;
    localparam logic [2:0] ST_DIV_WAIT  = 3'd5;
    localparam logic [2:0] ST_FINISH    = 3'd6;

    // Configuration registers.
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    logic [2:0]  radius_reg;
    logic [15:0] sscale_reg;
    logic [15:0] rscale_reg;

    logic [8:0]    w_eff;
    logic [8:0]    h_eff;
    logic [RW-1:0] r_eff;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    logic [7:0]  px_reg;
    logic [7:0]  py_reg;
    logic [DB-1:0] centre_reg;
    logic signed [DXW-1:0] dx_reg;
    logic signed [DXW-1:0] dy_reg;
    logic signed [DXW-1:0] r_pos;
    logic signed [DXW-1:0] r_neg;

    logic [23:0] res_depth_reg;
    logic        res_bad_reg;
    logic        out_valid_reg;
    bdf_pkg::out_item_t result_data_reg;

    logic [DB-1:0] frame_mem [MAX_WIDTH * MAX_HEIGHT];
    logic [DB-1:0] rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [DB-1:0] wr_data;
    logic          mem_we;
    logic [DB+23:0] din_ext;

    logic          in_fire;
    logic          in_bad;
    logic          empty_code;
    logic [DB-1:0] empty_val;
    logic [DB+23:0] centre_ext;

    logic [CW-1:0] nx;
    logic [CW-1:0] ny;
    logic          in_win;
    logic signed [2*DXW-1:0] dxx;
    logic signed [2*DXW-1:0] dyy;
    logic          walk_last;

    logic [16:0] wtab [EXP_TABLE_DEPTH];

    // Weight pipeline.
    logic            p1_valid, p2_valid, p3_valid, p4_valid, p5_valid, p6_valid;
    logic [DSW-1:0]  p1_dist2, p2_dist2;
    logic [DB-1:0]   p2_s, p3_s, p4_s, p5_s;
    logic [17:0]     p2_diff;
    logic            p2_zero, p3_zero, p4_zero;
    logic [35:0]     p3_diff2;
    logic [SPW-1:0]  p3_sp, p4_sp;
    logic [RGW-1:0]  p4_rg;
    logic [16:0]     p5_w, p6_w;
    logic [DB+16:0]  p6_prod;
    logic            pipe_busy;

    logic [DB-1:0]   s1_diff;
    logic [DB+17:0]  s1_diff_ext;
    logic            s1_big;
    logic [AAW-1:0]  s4_a;
    logic [IXW-1:0]  s4_scaled;
    logic [IXW-37:0] s4_idx;
    logic [16:0]     s4_w;

    logic [SWW-1:0]  sw_reg;
    logic [SDW-1:0]  sd_reg;
    logic [SDW:0]    div_num;
    logic            div_start;
    logic            div_done;
    logic [DB-1:0]   div_quo;
    logic [DB+23:0]  quo_ext;

    genvar gi;
    generate
        for (gi = 0; gi < EXP_TABLE_DEPTH; gi++)
        begin : g_wtab
            assign wtab[gi] = bdf_pkg::exp_entry(EXP_RATIO, gi);
        end
    endgenerate

    assign w_eff = (13'(width_reg) > 13'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : width_reg;
    assign h_eff = (13'(height_reg) > 13'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : height_reg;
    assign r_eff = (4'(radius_reg) > 4'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(radius_reg);
    assign r_pos = $signed({1'b0, r_eff});
    assign r_neg = -r_pos;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign in_bad    = (9'(in_data.pixel_x) >= w_eff) || (9'(in_data.pixel_y) >= h_eff);
    assign empty_val = '1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
            radius_reg <= 3'd2;
            sscale_reg <= 16'd128;
            rscale_reg <= 16'd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bdf_pkg::REG_IMAGE_WIDTH:   width_reg  <= cfg_data[8:0];
                bdf_pkg::REG_IMAGE_HEIGHT:  height_reg <= cfg_data[8:0];
                bdf_pkg::REG_FILTER_RADIUS: radius_reg <= cfg_data[2:0];
                bdf_pkg::REG_SPATIAL_SCALE: sscale_reg <= cfg_data;
                bdf_pkg::REG_RANGE_SCALE:   rscale_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Window walk addressing.
    assign nx = CW'(px_reg) + CW'(dx_reg);
    assign ny = CW'(py_reg) + CW'(dy_reg);
    assign in_win = !nx[CW-1] && !ny[CW-1] && (nx < CW'(w_eff)) && (ny < CW'(h_eff));
    assign dxx = dx_reg * dx_reg;
    assign dyy = dy_reg * dy_reg;
    assign walk_last = (dx_reg == r_pos) && (dy_reg == r_pos);

    always_comb
    begin
        if (state_reg == ST_IDLE)
            rd_addr = AW'(in_data.pixel_y) * AW'(MAX_WIDTH) + AW'(in_data.pixel_x);
        else
            rd_addr = AW'(ny) * AW'(MAX_WIDTH) + AW'(nx);
    end

    assign din_ext = (DB + 24)'(in_data.depth_in);
    assign wr_data = din_ext[DB-1:0];
    assign wr_addr = AW'(in_data.pixel_y) * AW'(MAX_WIDTH) + AW'(in_data.pixel_x);
    assign mem_we  = in_fire && !in_bad && (in_data.kind == bdf_pkg::KIND_STORE);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            frame_mem[wr_addr] <= wr_data;
        rd_data_reg <= frame_mem[rd_addr];
    end

    assign empty_code = (rd_data_reg == empty_val);
    assign centre_ext = (DB + 24)'(rd_data_reg);

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (!in_bad && (in_data.kind == bdf_pkg::KIND_QUERY))
                        state_next = ST_CENTRE;
                    else
                        state_next = ST_FINISH;
                end
            end
            ST_CENTRE:    state_next = empty_code ? ST_FINISH : ST_WALK;
            ST_WALK:      state_next = walk_last ? ST_DRAIN : ST_WALK;
            ST_DRAIN:     state_next = pipe_busy ? ST_DRAIN : ST_DIV_START;
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:  state_next = div_done ? ST_FINISH : ST_DIV_WAIT;
            ST_FINISH:    state_next = (!out_valid_reg || out_ready) ? ST_IDLE : ST_FINISH;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_FINISH && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign quo_ext = (DB + 24)'(div_quo);

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                px_reg        <= in_data.pixel_x;
                py_reg        <= in_data.pixel_y;
                res_depth_reg <= '0;
                res_bad_reg   <= in_bad;
            end
            ST_CENTRE:
            begin
                centre_reg    <= rd_data_reg;
                res_depth_reg <= centre_ext[23:0];
                dx_reg        <= r_neg;
                dy_reg        <= r_neg;
            end
            ST_WALK:
            begin
                if (dx_reg == r_pos)
                begin
                    dx_reg <= r_neg;
                    dy_reg <= dy_reg + 1'b1;
                end
                else
                begin
                    dx_reg <= dx_reg + 1'b1;
                end
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                    res_depth_reg <= quo_ext[23:0];
            end
            default: ;
        endcase
        if (state_reg == ST_FINISH && (!out_valid_reg || out_ready))
        begin
            result_data_reg.smoothed_depth <= res_depth_reg;
            result_data_reg.bad_coordinate <= res_bad_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_data = result_data_reg;

    // Weight pipeline: read, difference, squares, scaling, table, product, sums.
    assign s1_diff     = (rd_data_reg > centre_reg) ? rd_data_reg - centre_reg
                                                    : centre_reg - rd_data_reg;
    assign s1_diff_ext = (DB + 18)'(s1_diff);
    assign s1_big      = (rscale_reg != 16'd0) && (|s1_diff_ext[DB+17:18]);
    assign s4_a        = (AAW'(p4_sp) << 24) + AAW'(p4_rg);
    assign s4_scaled   = IXW'(s4_a) * IXW'(EXP_TABLE_DEPTH);
    assign s4_idx      = s4_scaled[IXW-1:36];
    assign s4_w        = (p4_zero || (s4_idx >= (IXW - 36)'(EXP_TABLE_DEPTH)))
                         ? 17'd0 : wtab[s4_idx[TIW-1:0]];
    assign pipe_busy   = p1_valid || p2_valid || p3_valid || p4_valid || p5_valid || p6_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid <= 1'b0;
            p2_valid <= 1'b0;
            p3_valid <= 1'b0;
            p4_valid <= 1'b0;
            p5_valid <= 1'b0;
            p6_valid <= 1'b0;
        end
        else
        begin
            p1_valid <= (state_reg == ST_WALK) && in_win;
            p2_valid <= p1_valid && !empty_code;
            p3_valid <= p2_valid;
            p4_valid <= p3_valid;
            p5_valid <= p4_valid;
            p6_valid <= p5_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_dist2 <= DSW'(dxx) + DSW'(dyy);
        p2_dist2 <= p1_dist2;
        p2_s     <= rd_data_reg;
        p2_diff  <= s1_diff_ext[17:0];
        p2_zero  <= s1_big;
        p3_diff2 <= 36'(p2_diff) * 36'(p2_diff);
        p3_sp    <= SPW'(p2_dist2) * SPW'(sscale_reg);
        p3_s     <= p2_s;
        p3_zero  <= p2_zero;
        p4_rg    <= RGW'(p3_diff2) * RGW'(rscale_reg);
        p4_sp    <= p3_sp;
        p4_s     <= p3_s;
        p4_zero  <= p3_zero;
        p5_w     <= s4_w;
        p5_s     <= p4_s;
        p6_prod  <= (DB + 17)'(p5_s) * (DB + 17)'(p5_w);
        p6_w     <= p5_w;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CENTRE)
        begin
            sw_reg <= '0;
            sd_reg <= '0;
        end
        else if (p6_valid)
        begin
            sw_reg <= sw_reg + SWW'(p6_w);
            sd_reg <= sd_reg + SDW'(p6_prod);
        end
    end

    // The centre always lands in the window with full weight, so sw_reg is never zero.
    assign div_num   = (SDW + 1)'(sd_reg) + (SDW + 1)'(sw_reg >> 1);
    assign div_start = (state_reg == ST_DIV_START);

    bdf_divider #(
        .NW (SDW + 1),
        .EW (SWW),
        .QW (DB)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (div_num),
        .denom    (sw_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    `BDF_ASSERT_IMPL(a_div_done_in_wait, div_done, state_reg == ST_DIV_WAIT)
    `BDF_ASSERT_NEXT(a_query_reads_centre,
        in_fire && !in_bad && (in_data.kind == bdf_pkg::KIND_QUERY), state_reg == ST_CENTRE)
    `BDF_ASSERT_IMPL(a_pipe_quiet_idle, state_reg == ST_IDLE, !pipe_busy)
    `BDF_ASSERT_NEXT(a_out_only_from_finish,
        !out_valid_reg && (state_reg != ST_FINISH), !out_valid_reg)

endmodule
